/* rtl/psa_pkg.sv */
package psa_pkg;

    localparam int NUM_SLOTS_DEF = 32;
    localparam int CFG_W         = 6;
    localparam int SLOT_W        = 5;
    localparam int PRIO_W        = 8;
    localparam logic [CFG_W-1:0] ACTIVE_RESET = CFG_W'(32);

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_FLUSH  = 2'd2,
        OP_QUERY  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_NOHANDLE = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FREE
    } t_state;

    typedef struct packed {
        t_op               op;
        logic [PRIO_W-1:0] priority_req;
        logic              pinned;
        logic [SLOT_W-1:0] slot;
        logic              slot_none;
    } t_req;

    typedef struct packed {
        logic              ok;
        logic [SLOT_W-1:0] granted_slot;
        logic              evicted;
        t_status           status;
    } t_rsp;

    typedef struct packed {
        logic              pinned;
        logic [PRIO_W-1:0] prio;
    } t_meta;

    typedef struct packed {
        logic set_use;
        logic clr_use;
        logic flush;
    } t_tbl_ctl;

endpackage

/* rtl/psa_slot_table.sv */
module psa_slot_table #(
    parameter int NUM_SLOTS = psa_pkg::NUM_SLOTS_DEF,
    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  psa_pkg::t_tbl_ctl i_ctl,
    input  logic [IDX_W-1:0] i_wr_addr,
    input  psa_pkg::t_meta   i_meta,
    input  logic [IDX_W-1:0] i_use_addr,
    input  logic [IDX_W-1:0] i_rd_addr,
    output logic             o_use_bit,
    output psa_pkg::t_meta   o_meta
);
    import psa_pkg::*;

    logic [NUM_SLOTS-1:0] r_use;
    t_meta                r_mem [NUM_SLOTS];
    t_meta                r_rd;

    // In-use flags live in flip-flops so that reset and flush clear them at once.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use <= '0;
        end else if (i_ctl.flush) begin
            r_use <= '0;
        end else if (i_ctl.set_use) begin
            r_use[i_wr_addr] <= 1'b1;
        end else if (i_ctl.clr_use) begin
            r_use[i_wr_addr] <= 1'b0;
        end
    end

    // Pinned flag and priority: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_ctl.set_use) begin
            r_mem[i_wr_addr] <= i_meta;
        end
        r_rd <= r_mem[i_rd_addr];
    end

    assign o_use_bit = r_use[i_use_addr];
    assign o_meta    = r_rd;

endmodule

/* rtl/psa_scan_ctrl.sv */
module psa_scan_ctrl #(
    parameter int NUM_SLOTS = psa_pkg::NUM_SLOTS_DEF,
    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1,
    localparam int CNT_W = $clog2(NUM_SLOTS + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  psa_pkg::t_req     i_req,
    input  logic [CNT_W-1:0]  i_active,
    output logic              o_busy,
    output logic              o_done,
    output psa_pkg::t_rsp     o_rsp,
    output psa_pkg::t_tbl_ctl o_ctl,
    output logic [IDX_W-1:0]  o_wr_addr,
    output psa_pkg::t_meta    o_meta,
    output logic [IDX_W-1:0]  o_use_addr,
    output logic [IDX_W-1:0]  o_rd_addr,
    input  logic              i_use_bit,
    input  psa_pkg::t_meta    i_meta
);
    import psa_pkg::*;

    localparam int SW = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic [CNT_W-1:0] r_hint, n_hint;
    logic [IDX_W-1:0] r_grant, n_grant;
    logic             r_evict, n_evict;
    t_req             r_req, n_req;
    logic             r_done, n_done;
    t_rsp             r_rsp, n_rsp;

    logic             accept;
    logic             hint_ok;
    logic             slot_in;
    logic             cmp_hit;
    logic [CNT_W-1:0] idx_inc;
    logic             scan_last;
    logic             free_end;

    assign accept    = i_start && (r_state == S_IDLE);
    assign hint_ok   = r_hint < i_active;
    assign slot_in   = SW'(i_req.slot) < SW'(i_active);
    assign idx_inc   = r_idx + CNT_W'(1);
    assign scan_last = idx_inc == i_active;
    assign free_end  = r_idx == i_active;

    // The shared compare unit: may the occupant under the counter be evicted?
    assign cmp_hit = !i_meta.pinned && (i_meta.prio <= r_req.priority_req);

    assign o_use_addr = (r_state == S_IDLE) ? IDX_W'(i_req.slot) : r_idx[IDX_W-1:0];
    assign o_rd_addr  = n_idx[IDX_W-1:0];

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && i_req.op == OP_ADD) begin
                    n_state = hint_ok ? S_FREE : S_SCAN;
                end
            end
            S_SCAN: begin
                if (!i_use_bit || cmp_hit) begin
                    n_state = S_FREE;
                end else if (scan_last) begin
                    n_state = S_IDLE;
                end
            end
            S_FREE: begin
                if (free_end || !i_use_bit) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_idx     = r_idx;
        n_hint    = r_hint;
        n_grant   = r_grant;
        n_evict   = r_evict;
        n_req     = r_req;
        n_done    = 1'b0;
        n_rsp     = r_rsp;
        o_ctl     = '0;
        o_wr_addr = r_idx[IDX_W-1:0];
        o_meta    = '{pinned: r_req.pinned, prio: r_req.priority_req};
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_req = i_req;
                    n_rsp = '{ok: 1'b0, granted_slot: '0, evicted: 1'b0, status: ST_OK};
                    case (i_req.op)
                        OP_ADD: begin
                            n_idx   = '0;
                            n_evict = 1'b0;
                            if (hint_ok) begin
                                o_ctl.set_use = 1'b1;
                                o_wr_addr     = r_hint[IDX_W-1:0];
                                o_meta        = '{pinned: i_req.pinned,
                                                  prio: i_req.priority_req};
                                n_grant       = r_hint[IDX_W-1:0];
                            end
                        end
                        OP_REMOVE: begin
                            n_done = 1'b1;
                            if (i_req.slot_none) begin
                                n_rsp.status = ST_NOHANDLE;
                            end else begin
                                n_rsp.ok = 1'b1;
                                if (slot_in && i_use_bit) begin
                                    o_ctl.clr_use = 1'b1;
                                    o_wr_addr     = IDX_W'(i_req.slot);
                                    n_hint        = CNT_W'(i_req.slot);
                                end
                            end
                        end
                        OP_FLUSH: begin
                            n_done      = 1'b1;
                            o_ctl.flush = 1'b1;
                            n_hint      = '0;
                            n_rsp.ok    = 1'b1;
                        end
                        OP_QUERY: begin
                            n_done = 1'b1;
                            if (i_req.slot_none) begin
                                n_rsp.status = ST_NOHANDLE;
                            end else begin
                                n_rsp.ok = slot_in && i_use_bit;
                            end
                        end
                        default: n_done = 1'b1;
                    endcase
                end
            end
            S_SCAN: begin
                if (!i_use_bit || cmp_hit) begin
                    // Take a free slot, or overwrite the evictable occupant.
                    o_ctl.set_use = 1'b1;
                    n_grant       = r_idx[IDX_W-1:0];
                    n_evict       = i_use_bit;
                    n_idx         = idx_inc;
                end else if (scan_last) begin
                    n_done       = 1'b1;
                    n_rsp.status = ST_FULL;
                end else begin
                    n_idx = idx_inc;
                end
            end
            S_FREE: begin
                if (free_end || !i_use_bit) begin
                    n_hint = free_end ? CNT_W'(NUM_SLOTS) : r_idx;
                    n_done = 1'b1;
                    n_rsp  = '{ok: 1'b1, granted_slot: SLOT_W'(r_grant),
                               evicted: r_evict, status: ST_OK};
                end else begin
                    n_idx = idx_inc;
                end
            end
            default: n_done = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_hint  <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_hint  <= n_hint;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_grant <= n_grant;
        r_evict <= n_evict;
        r_req   <= n_req;
        r_rsp   <= n_rsp;
    end

    assign o_busy = r_state != S_IDLE;
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule

/* rtl/priority_slot_allocator.sv */
// Channel   | Ports                                  | Handshake
// ----------+----------------------------------------+-----------------------------------
// command   | start, busy, i_req                     | word taken when start && !busy
// result    | o_done, o_rsp                          | word valid for the one o_done cycle
// config    | i_cfg_valid, o_cfg_ready, i_cfg_data   | word taken when valid && ready
//
// Remove, flush and query finish in the accept cycle: their result word shows on the
// cycle after accept and busy never rises. An add walks the slot table with a single
// counter and one priority compare per cycle, so busy stays high while it walks the active
// slots, and the result word follows on the cycle busy falls.
// A synchronous reset of one cycle clears the in-use flags and the hint; no clearing
// pass is needed. Results cannot be held off by the receiver.
module priority_slot_allocator #(
    parameter int NUM_SLOTS = psa_pkg::NUM_SLOTS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  psa_pkg::t_req             i_req,
    output logic                      o_done,
    output psa_pkg::t_rsp             o_rsp,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [psa_pkg::CFG_W-1:0] i_cfg_data
);
    import psa_pkg::*;

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W = $clog2(NUM_SLOTS + 1);
    localparam int CW    = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    logic [CFG_W-1:0] r_active;
    logic [CW-1:0]    act_ext;
    logic [CNT_W-1:0] active_n;

    t_tbl_ctl         tbl_ctl;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] use_addr;
    logic [IDX_W-1:0] rd_addr;
    t_meta            wr_meta;
    t_meta            rd_meta;
    logic             use_bit;

    // The active slot count is only changed while the block is idle.
    assign o_cfg_ready = !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= ACTIVE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_active <= i_cfg_data;
        end
    end

    // A count of zero behaves as one slot; anything beyond the table is clipped.
    assign act_ext = CW'(r_active);

    always_comb begin
        if (act_ext == '0) begin
            active_n = CNT_W'(1);
        end else if (act_ext > CW'(NUM_SLOTS)) begin
            active_n = CNT_W'(NUM_SLOTS);
        end else begin
            active_n = CNT_W'(act_ext);
        end
    end

    psa_scan_ctrl #(
        .NUM_SLOTS(NUM_SLOTS)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_req     (i_req),
        .i_active  (active_n),
        .o_busy    (busy),
        .o_done    (o_done),
        .o_rsp     (o_rsp),
        .o_ctl     (tbl_ctl),
        .o_wr_addr (wr_addr),
        .o_meta    (wr_meta),
        .o_use_addr(use_addr),
        .o_rd_addr (rd_addr),
        .i_use_bit (use_bit),
        .i_meta    (rd_meta)
    );

    psa_slot_table #(
        .NUM_SLOTS(NUM_SLOTS)
    ) u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (tbl_ctl),
        .i_wr_addr (wr_addr),
        .i_meta    (wr_meta),
        .i_use_addr(use_addr),
        .i_rd_addr (rd_addr),
        .o_use_bit (use_bit),
        .o_meta    (rd_meta)
    );

endmodule

/* rtl/psa_checker.sv */
module psa_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input logic          busy,
    input psa_pkg::t_req i_req,
    input logic          o_done,
    input psa_pkg::t_rsp o_rsp
);
    import psa_pkg::*;

    // Every command other than add answers on the very next cycle.
    a_quick_ops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_req.op != OP_ADD) |=> (o_done && !busy))
        else $error("non-add command did not answer on the next cycle");

    // An accepted add always makes the sequencer busy in the cycle after it is accepted.
    a_add_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_req.op == OP_ADD) |=> busy)
        else $error("add accepted without the sequencer going busy");

    // When an add finishes, its result is shown in the cycle busy drops.
    a_end_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_done)
        else $error("busy dropped without a result word");

    // A full table reports nothing granted and nothing evicted.
    a_full_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_rsp.status == ST_FULL) |->
            (!o_rsp.ok && !o_rsp.evicted && o_rsp.granted_slot == '0))
        else $error("full result carries a grant");

    // An eviction is only ever reported by a successful add.
    a_evict_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_rsp.evicted) |-> (o_rsp.ok && o_rsp.status == ST_OK))
        else $error("eviction reported on a failed result");

endmodule

bind priority_slot_allocator psa_checker u_psa_checker (
    .i_clk  (i_clk),
    .i_rst_n(i_rst_n),
    .start  (start),
    .busy   (busy),
    .i_req  (i_req),
    .o_done (o_done),
    .o_rsp  (o_rsp)
);
